@@ hw/rtl/storm_rain_alert_predictor_unit_defines.svh @@
// Assertion helpers shared by the RTL. Both sample on clk and are
// disabled while rst_n is low.
`ifndef STORM_RAIN_ALERT_PREDICTOR_UNIT_DEFINES_SVH
`define STORM_RAIN_ALERT_PREDICTOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define SRAP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srap assertion failed");

// Next-cycle implication
`define SRAP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srap assertion failed");

`endif

@@ hw/rtl/srap_pkg.sv @@
package srap_pkg;

    // Register indexes
    localparam logic [3:0] REG_STORM_W   = 4'd0;
    localparam logic [3:0] REG_RAIN_W    = 4'd1;
    localparam logic [3:0] REG_STORM_THR = 4'd2;
    localparam logic [3:0] REG_RAIN_THR  = 4'd3;
    localparam logic [3:0] REG_RECOVERY  = 4'd4;
    localparam logic [3:0] REG_BOUNDS    = 4'd5;
    localparam logic [3:0] REG_SPAN      = 4'd6;
    localparam logic [3:0] REG_LIMITS    = 4'd7;

    // Score jobs, run in this order
    localparam logic [1:0] JOB_LEVEL = 2'd0;
    localparam logic [1:0] JOB_RATE  = 2'd1;
    localparam logic [1:0] JOB_HUM   = 2'd2;
    localparam logic [1:0] JOB_TEMP  = 2'd3;

    // ceil(2^29 / 75): exact floor division by 75 for numerators below 2^22
    localparam logic [22:0] RECIP_75 = 23'd7158279;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DIV_GO   = 7'b0000010,
        ST_DIV_WAIT = 7'b0000100,
        ST_TEND     = 7'b0001000,
        ST_MAC      = 7'b0010000,
        ST_CONF     = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       div_start;
        logic [1:0] job;
        logic       div_store;
        logic       tend;
        logic       mac_clear;
        logic       mac_en;
        logic [2:0] mac_idx;
        logic       conf;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic        flag;
        logic [14:0] base;
        logic [14:0] trough;
        logic [31:0] eta;
    } alert_t;

    // Seconds to arrival from the pressure tendency
    function automatic logic [31:0] arrival_secs(input logic signed [12:0] rate);
        logic [31:0] s;
        if (rate >= 13'sd0)
            s = 32'd86400;
        else if (rate <= -13'sd200)
            s = 32'd7200;
        else if (rate <= -13'sd100)
            s = 32'd14400;
        else if (rate <= -13'sd50)
            s = 32'd28800;
        else
            s = 32'd57600;
        return s;
    endfunction

    // Tendency bin in Q1.15
    function automatic logic [15:0] tendency_bin(input logic signed [12:0] rate);
        logic [15:0] b;
        if (rate < -13'sd300)
            b = 16'd32768;
        else if (rate < -13'sd150)
            b = 16'd24576;
        else if (rate < -13'sd50)
            b = 16'd16384;
        else if (rate < 13'sd0)
            b = 16'd8192;
        else if (rate < 13'sd50)
            b = 16'd3277;
        else
            b = 16'd0;
        return b;
    endfunction

endpackage

@@ hw/rtl/srap_div.sv @@
module srap_div
    import srap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [11:0] den,
    output logic        done,
    output logic [32:0] quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [11:0] rem_reg;
    logic [32:0] sq_reg;
    logic [12:0] rem_shift;
    logic        ge;

    // One restoring step per cycle
    assign rem_shift = {rem_reg, sq_reg[32]};
    assign ge        = rem_shift >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the numerator through, quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            sq_reg  <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 12'(rem_shift - {1'b0, den}) : rem_shift[11:0];
            sq_reg  <= {sq_reg[31:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = sq_reg;

endmodule

@@ hw/rtl/srap_dp.sv @@
module srap_dp
    import srap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               cfg_valid,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [12:0] pressure_rate,
    input  logic [14:0]        current_pressure,
    input  logic [14:0]        max_pressure,
    input  logic signed [14:0] humidity_trend,
    input  logic signed [14:0] temp_trend,
    input  logic [31:0]        now_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         storm_confidence,
    output logic [6:0]         rain_confidence,
    output logic               storm_active,
    output logic               rain_active,
    output logic [31:0]        storm_arrival,
    output logic [31:0]        rain_arrival
);

    // Configuration
    logic [31:0] storm_w_reg, rain_w_reg, bounds_reg;
    logic [15:0] storm_thr_reg, rain_thr_reg, limits_reg;
    logic [8:0]  recovery_reg;
    logic [10:0] span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            storm_w_reg   <= 32'h4040_4040;
            rain_w_reg    <= 32'h4040_4040;
            storm_thr_reg <= 16'd15400;
            rain_thr_reg  <= 16'd12830;
            recovery_reg  <= 9'd128;
            bounds_reg    <= 32'd655370200;
            span_reg      <= 11'd200;
            limits_reg    <= 16'd49280;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STORM_W:   storm_w_reg   <= cfg_data;
                REG_RAIN_W:    rain_w_reg    <= cfg_data;
                REG_STORM_THR: storm_thr_reg <= cfg_data[15:0];
                REG_RAIN_THR:  rain_thr_reg  <= cfg_data[15:0];
                REG_RECOVERY:  recovery_reg  <= cfg_data[8:0];
                REG_BOUNDS:    bounds_reg    <= cfg_data;
                REG_SPAN:      span_reg      <= cfg_data[10:0];
                REG_LIMITS:    limits_reg    <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // Captured word; a missing reading falls back to the window maximum
    logic signed [12:0] rate_reg;
    logic [14:0]        cur_reg, maxp_reg;
    logic signed [14:0] hum_reg, tmp_reg;
    logic [31:0]        now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rate_reg <= pressure_rate;
            cur_reg  <= (current_pressure == 15'd0) ? max_pressure : current_pressure;
            maxp_reg <= max_pressure;
            hum_reg  <= humidity_trend;
            tmp_reg  <= temp_trend;
            now_reg  <= now_time;
        end
    end

    // Level ramp numerator
    logic [15:0]        lo, hi;
    logic [10:0]        span_eff;
    logic [16:0]        bst;
    logic [15:0]        dmp;
    logic               below, above;
    logic signed [17:0] bdiff;
    logic               bneg;
    logic [15:0]        dlo;
    logic [14:0]        dhi;
    logic signed [34:0] prod_lo;
    logic [32:0]        mag_lo;
    logic [31:0]        prod_hi;
    logic [32:0]        num_level;

    assign lo       = bounds_reg[31:16];
    assign hi       = bounds_reg[15:0];
    assign span_eff = (span_reg == 11'd0) ? 11'd1 : span_reg;
    assign bst      = {limits_reg[15:8], 9'b0};
    assign dmp      = {limits_reg[7:0], 8'b0};
    assign below    = (cur_reg != 15'd0) && ({1'b0, cur_reg} < lo);
    assign above    = (cur_reg != 15'd0) && !below && ({1'b0, cur_reg} > hi);
    assign bdiff    = $signed({1'b0, bst}) - 18'sd65536;
    assign bneg     = bdiff < 18'sd0;
    assign dlo      = lo - {1'b0, cur_reg};
    assign dhi      = cur_reg - hi[14:0];
    assign prod_lo  = $signed({1'b0, dlo}) * bdiff;
    assign mag_lo   = bneg ? 33'(-prod_lo) : prod_lo[32:0];
    assign prod_hi  = {17'b0, dhi} * (17'h10000 - {1'b0, dmp});
    assign num_level = below ? mag_lo : (above ? {1'b0, prod_hi} : 33'd0);

    // Trend score operand and its full-scale value
    logic signed [16:0] v_sel;
    logic signed [16:0] v_full;
    logic [34:0]        recip_prod;
    logic               div_done;
    logic [32:0]        quo;

    always_comb
    begin
        case (cmd.job)
            JOB_RATE: v_sel = 17'sd0 - {{4{rate_reg[12]}}, rate_reg};
            JOB_HUM:  v_sel = {{2{hum_reg[14]}}, hum_reg};
            JOB_TEMP: v_sel = 17'sd0 - {{2{tmp_reg[14]}}, tmp_reg};
            default:  v_sel = '0;
        endcase
        v_full = (cmd.job == JOB_HUM) ? 17'sd2400 : 17'sd600;
    end

    // v*32768/600 = v*4096/75 and v*32768/2400 = v*1024/75
    assign recip_prod = {23'b0, v_sel[11:0]} * {12'b0, RECIP_75};

    srap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_level),
        .den   ({1'b0, span_eff}),
        .done  (div_done),
        .quo   (quo)
    );

    // Level factor from the quotient, clamped to the boost/damp limits and floored for very deep ramps
    logic signed [34:0] f_raw, f_lim;
    logic signed [34:0] bst35, dmp35;
    logic [15:0]        score;

    always_comb
    begin
        bst35 = $signed({18'b0, bst});
        dmp35 = $signed({19'b0, dmp});
        if (below)
        begin
            f_raw = bneg ? 35'sd65536 - $signed({2'b0, quo})
                         : 35'sd65536 + $signed({2'b0, quo});
            f_lim = (f_raw > bst35) ? bst35 : f_raw;
        end
        else if (above)
        begin
            f_raw = 35'sd65536 - $signed({2'b0, quo});
            f_lim = (f_raw < dmp35) ? dmp35 : f_raw;
        end
        else
        begin
            f_raw = 35'sd65536;
            f_lim = f_raw;
        end
        if (f_lim < -35'sd2147483648)
            f_lim = -35'sd2147483648;
        if (v_sel <= 17'sd0)
            score = 16'd0;
        else if (v_sel >= v_full)
            score = 16'd32768;
        else if (cmd.job == JOB_HUM)
            score = recip_prod[34:19];
        else
            score = recip_prod[32:17];
    end

    logic signed [32:0] f_reg;
    logic [15:0]        sc0_reg, sc2_reg, sc3_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            case (cmd.job)
                JOB_LEVEL: f_reg   <= f_lim[32:0];
                JOB_RATE:  sc0_reg <= score;
                JOB_HUM:   sc2_reg <= score;
                JOB_TEMP:  sc3_reg <= score;
                default:   ;
            endcase
        end
    end

    // Tendency score: bin times level factor, truncated toward zero
    logic signed [49:0] tprod, tadj;
    logic signed [33:0] zq;
    logic signed [27:0] sc1_reg;

    assign tprod = $signed({1'b0, tendency_bin(rate_reg)}) * f_reg;
    assign tadj  = (tprod < 50'sd0) ? tprod + 50'sd65535 : tprod;
    assign zq    = 34'(tadj >>> 16);

    always_ff @(posedge clk)
    begin
        if (cmd.tend)
        begin
            if (zq > 34'sd32768)
                sc1_reg <= 28'sd32768;
            else if (zq < -34'sd134217728)
                sc1_reg <= -28'sd134217728;
            else
                sc1_reg <= zq[27:0];
        end
    end

    // Weighted sums, one product a cycle
    logic [7:0]         w_sel;
    logic [31:0]        w_word;
    logic signed [27:0] sc_sel;
    logic signed [36:0] mprod;
    logic signed [37:0] acc_reg [2];

    always_comb
    begin
        w_word = cmd.mac_idx[2] ? rain_w_reg : storm_w_reg;
        case (cmd.mac_idx[1:0])
            2'd0:    begin w_sel = w_word[31:24]; sc_sel = $signed({12'b0, sc0_reg}); end
            2'd1:    begin w_sel = w_word[23:16]; sc_sel = sc1_reg; end
            2'd2:    begin w_sel = w_word[15:8];  sc_sel = $signed({12'b0, sc2_reg}); end
            default: begin w_sel = w_word[7:0];   sc_sel = $signed({12'b0, sc3_reg}); end
        endcase
    end

    assign mprod = $signed({1'b0, w_sel}) * sc_sel;

    always_ff @(posedge clk)
    begin
        if (cmd.mac_clear)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
        end
        else if (cmd.mac_en)
        begin
            acc_reg[cmd.mac_idx[2]] <= acc_reg[cmd.mac_idx[2]] + 38'(mprod);
        end
    end

    // Percent with round half up, clamped to 0..100
    function automatic logic [6:0] to_percent(input logic signed [37:0] s);
        logic signed [45:0] n;
        logic [6:0]         p;
        n = 46'(s) * 46'sd100 + 46'sd4194304;
        if (n < 46'sd0)
            p = 7'd0;
        else if (n[45:23] > 23'd100)
            p = 7'd100;
        else
            p = n[29:23];
        return p;
    endfunction

    logic [6:0] sconf_reg, rconf_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.conf)
        begin
            sconf_reg <= to_percent(acc_reg[0]);
            rconf_reg <= to_percent(acc_reg[1]);
        end
    end

    // Trigger/clear hysteresis with trough tracking
    function automatic alert_t alert_step(input alert_t st, input logic [6:0] conf,
                                          input logic [15:0] thr, input logic [14:0] cur,
                                          input logic [14:0] maxp, input logic [31:0] arr,
                                          input logic [8:0] rr);
        alert_t             nx;
        logic [14:0]        tr;
        logic signed [15:0] drop;
        logic signed [15:0] diff;
        logic signed [26:0] lhs;
        logic signed [26:0] rhs;
        logic               rec;
        nx   = st;
        tr   = ((cur != 15'd0) && (cur < st.trough)) ? cur : st.trough;
        drop = $signed({1'b0, st.base}) - $signed({1'b0, tr});
        diff = $signed({1'b0, cur}) - $signed({1'b0, tr});
        lhs  = $signed({{3{diff[15]}}, diff, 8'b0});
        rhs  = $signed({1'b0, rr}) * drop;
        rec  = (drop > 16'sd1) ? (lhs >= rhs) : (rr <= 9'd256);
        if (!st.flag)
        begin
            if ({1'b0, conf} >= thr[15:8])
            begin
                nx.flag   = 1'b1;
                nx.base   = maxp;
                nx.trough = cur;
                nx.eta    = arr;
            end
        end
        else
        begin
            nx.trough = tr;
            if (({1'b0, conf} < thr[7:0]) && rec)
                nx.flag = 1'b0;
            else
                nx.eta = arr;
        end
        return nx;
    endfunction

    alert_t      storm_reg, rain_reg, storm_next, rain_next;
    logic [31:0] arr;
    logic        out_valid_reg;

    assign arr        = now_reg + arrival_secs(rate_reg);
    assign storm_next = alert_step(storm_reg, sconf_reg, storm_thr_reg, cur_reg, maxp_reg,
                                   arr, recovery_reg);
    assign rain_next  = alert_step(rain_reg, rconf_reg, rain_thr_reg, cur_reg, maxp_reg,
                                   arr, recovery_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            storm_reg     <= '0;
            rain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                storm_reg     <= storm_next;
                rain_reg      <= rain_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word
    logic [6:0]  sconf_out_reg, rconf_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            sconf_out_reg <= sconf_reg;
            rconf_out_reg <= rconf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign storm_confidence = sconf_out_reg;
    assign rain_confidence  = rconf_out_reg;
    assign storm_active     = storm_reg.flag;
    assign rain_active      = rain_reg.flag;
    assign storm_arrival    = storm_reg.eta;
    assign rain_arrival     = rain_reg.eta;

    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

@@ hw/rtl/srap_ctrl.sv @@
`include "storm_rain_alert_predictor_unit_defines.svh"

module srap_ctrl
    import srap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [1:0] job_reg, job_next;
    logic [2:0] mac_reg, mac_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_LEVEL;
            mac_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            mac_reg   <= mac_next;
        end
    end

    // Sequencer: level division, three trend scores, tendency scale, eight MACs,
    // percent, commit
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        mac_next   = mac_reg;
        cmd        = '0;
        cmd.job    = job_reg;
        cmd.mac_idx = mac_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    job_next    = JOB_LEVEL;
                    state_next  = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                if (job_reg == JOB_LEVEL)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
                else
                begin
                    // trend scores come from the reciprocal multiply, with no divider run
                    cmd.div_store = 1'b1;
                    if (job_reg == JOB_TEMP)
                        state_next = ST_TEND;
                    else
                        job_next = job_reg + 2'd1;
                end
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    job_next      = JOB_RATE;
                    state_next    = ST_DIV_GO;
                end
            end
            ST_TEND:
            begin
                cmd.tend      = 1'b1;
                cmd.mac_clear = 1'b1;
                mac_next      = '0;
                state_next    = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                mac_next   = mac_reg + 3'd1;
                if (mac_reg == 3'd7)
                    state_next = ST_CONF;
            end
            ST_CONF:
            begin
                cmd.conf   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    `SRAP_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_reg == ST_DIV_GO)
    `SRAP_ASSERT_NXT(a_mac_to_conf, (state_reg == ST_MAC) && (mac_reg == 3'd7),
                     state_reg == ST_CONF)
    `SRAP_ASSERT_IMP(a_commit_free, cmd.commit, sts.out_free)

endmodule

@@ hw/rtl/storm_rain_alert_predictor_unit.sv @@
// Storm and rain alert predictor.
// Input channel (in_valid/in_ready) takes one weather word: pressure tendency,
// current and window-maximum pressure, humidity and temperature trends, time.
// Output channel (out_valid/out_ready) returns one word per input: both
// confidences, both alert flags and both arrival estimates.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write it only while no word is in flight. Unknown indexes are ignored.
// After input accept, one radix-2 divider runs the level ramp (33 steps),
// the three trend scores use a reciprocal multiply one a cycle, then one
// multiplier forms the eight weighted products. One word is worked on at a
// time: the next word is taken only after the last result is committed.
// The result sits in an output register; in_ready returns as soon as it is
// loaded, so the next word may be taken while the receiver stalls. A second
// result waits in the sequencer until the output register is taken.
// Reset restores the default register values and clears both alerts, their
// baselines, troughs and arrival estimates; out_valid drops.
module storm_rain_alert_predictor_unit
    import srap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [12:0] pressure_rate,
    input  logic [14:0]        current_pressure,
    input  logic [14:0]        max_pressure,
    input  logic signed [14:0] humidity_trend,
    input  logic signed [14:0] temp_trend,
    input  logic [31:0]        now_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         storm_confidence,
    output logic [6:0]         rain_confidence,
    output logic               storm_active,
    output logic               rain_active,
    output logic [31:0]        storm_arrival,
    output logic [31:0]        rain_arrival
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    srap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srap_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pressure_rate    (pressure_rate),
        .current_pressure (current_pressure),
        .max_pressure     (max_pressure),
        .humidity_trend   (humidity_trend),
        .temp_trend       (temp_trend),
        .now_time         (now_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .storm_confidence (storm_confidence),
        .rain_confidence  (rain_confidence),
        .storm_active     (storm_active),
        .rain_active      (rain_active),
        .storm_arrival    (storm_arrival),
        .rain_arrival     (rain_arrival)
    );

endmodule
